>>> hw/rtl/dmwbc_pkg.sv
package dmwbc_pkg;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   localparam logic [1:0] CSR_MEM_READ_COST   = 2'd0;
   localparam logic [1:0] CSR_MEM_WRITE_COST  = 2'd1;
   localparam logic [1:0] CSR_CACHE_READ_COST = 2'd2;
   localparam logic [1:0] CSR_CACHE_WRITE_COST = 2'd3;

   typedef struct packed {
      logic latch_req;
      logic add_mem_read;
      logic add_mem_write;
      logic add_cache;
      logic set_hit;
      logic set_wb;
      logic wb_step;
      logic fill_step;
      logic fill_done;
      logic access;
      logic respond;
      logic sweep_step;
      logic cnt_clear;
   } ctrl_type;

   typedef struct packed {
      logic line_hit;
      logic line_dirty;
      logic cnt_last;
      logic sweep_last;
      logic is_rw;
   } status_type;

endpackage

>>> hw/rtl/dmwbc_ctrl.sv
module dmwbc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  dmwbc_pkg::status_type status,
   output dmwbc_pkg::ctrl_type   ctrl
);

   localparam logic [2:0] ST_SWEEP = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOOK  = 3'd2;
   localparam logic [2:0] ST_WB    = 3'd3;
   localparam logic [2:0] ST_FILL  = 3'd4;
   localparam logic [2:0] ST_ACC   = 3'd5;
   localparam logic [2:0] ST_RSP   = 3'd6;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_SWEEP;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ctrl = '0;
      unique case (state_ff)
         ST_SWEEP: begin
            ctrl.sweep_step = 1'b1;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               ctrl.latch_req = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            ctrl.cnt_clear = 1'b1;
            if (!status.is_rw) begin
               state_in = ST_RSP;
            end else if (status.line_hit) begin
               ctrl.set_hit = 1'b1;
               state_in = ST_ACC;
            end else begin
               ctrl.add_mem_read = 1'b1;
               if (status.line_dirty) begin
                  ctrl.set_wb = 1'b1;
                  state_in = ST_WB;
               end else begin
                  state_in = ST_FILL;
               end
            end
         end
         ST_WB: begin
            ctrl.wb_step = 1'b1;
            if (status.cnt_last) begin
               ctrl.add_mem_write = 1'b1;
               ctrl.cnt_clear = 1'b1;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            ctrl.fill_step = 1'b1;
            if (status.cnt_last) begin
               ctrl.fill_done = 1'b1;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            ctrl.access = 1'b1;
            ctrl.add_cache = 1'b1;
            state_in = ST_RSP;
         end
         ST_RSP: begin
            ctrl.respond = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> hw/rtl/dmwbc_datapath.sv
module dmwbc_datapath #(
   parameter int LINES        = 256,
   parameter int LINE_BYTES   = 64,
   parameter int MEMORY_BYTES = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dmwbc_pkg::ctrl_type   ctrl,
   output dmwbc_pkg::status_type status,
   input  logic                  csr_valid,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_data,
   input  logic [1:0]            req_operation,
   input  logic [15:0]           req_address,
   input  logic [31:0]           req_write_data,
   output logic                  rsp_valid,
   output logic [31:0]           rsp_read_data,
   output logic                  rsp_hit,
   output logic                  rsp_wrote_back,
   output logic [31:0]           rsp_time_now
);

   localparam int WPL   = LINE_BYTES / 4;
   localparam int OFFW  = $clog2(WPL);
   localparam int IDXW  = $clog2(LINES);
   localparam int MEMW  = $clog2(MEMORY_BYTES / 4);
   localparam int BLKW  = MEMW - OFFW;
   localparam int TAGW  = (BLKW > IDXW) ? BLKW - IDXW : 1;
   localparam int CWW   = IDXW + OFFW;
   localparam int SWW   = (MEMW > CWW) ? MEMW : CWW;
   localparam int CTAGW = BLKW - IDXW;

   logic [31:0] mem_ram   [MEMORY_BYTES/4];
   logic [31:0] cache_ram [LINES*WPL];
   logic [TAGW-1:0] tag_ram [LINES];
   logic [LINES-1:0] valid_ff, dirty_ff;

   logic [15:0] mrc_ff, mwc_ff, crc_ff, cwc_ff;
   logic [31:0] time_ff;
   logic [1:0]  op_ff;
   logic [MEMW-1:0] wa_ff;
   logic [31:0] wd_ff;
   logic [OFFW:0] cnt_ff;
   logic [SWW:0] sw_ff;
   logic hit_ff, wb_ff;
   logic [31:0] crd_ff, mrd_ff, rd_word;
   logic [TAGW-1:0] tagq_ff;

   logic [IDXW-1:0] idx;
   logic [IDXW-1:0] req_idx;
   logic [TAGW-1:0] tag;
   logic [OFFW-1:0] woff;
   logic [OFFW-1:0] cnt;
   logic [BLKW-1:0] oldblk;

   assign woff = wa_ff[OFFW-1:0];
   assign idx  = wa_ff[CWW-1:OFFW];
   assign req_idx = req_address[CWW+1:OFFW+2];
   generate
      if (CTAGW > 0) begin : g_tag
         assign tag    = wa_ff[MEMW-1:CWW];
         assign oldblk = {tagq_ff, idx};
      end else begin : g_notag
         assign tag    = '0;
         assign oldblk = idx[BLKW-1:0];
      end
   endgenerate
   assign cnt = cnt_ff[OFFW-1:0];

   assign status.is_rw      = (op_ff == dmwbc_pkg::OP_READ) || (op_ff == dmwbc_pkg::OP_WRITE);
   assign status.line_hit   = valid_ff[idx] && (tagq_ff == tag);
   assign status.line_dirty = valid_ff[idx] && dirty_ff[idx];
   assign status.cnt_last   = (cnt_ff == (OFFW+1)'(WPL));
   assign status.sweep_last = (sw_ff == (SWW+1)'(MEMORY_BYTES/4 - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         mrc_ff <= 16'd100;
         mwc_ff <= 16'd50;
         crc_ff <= 16'd1;
         cwc_ff <= 16'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            dmwbc_pkg::CSR_MEM_READ_COST:    mrc_ff <= csr_data;
            dmwbc_pkg::CSR_MEM_WRITE_COST:   mwc_ff <= csr_data;
            dmwbc_pkg::CSR_CACHE_READ_COST:  crc_ff <= csr_data;
            dmwbc_pkg::CSR_CACHE_WRITE_COST: cwc_ff <= csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff <= '0;
      end else if (ctrl.sweep_step) begin
         sw_ff <= sw_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.latch_req) begin
         op_ff <= req_operation;
         wa_ff <= req_address[MEMW+1:2];
         wd_ff <= req_write_data;
      end
      tagq_ff <= tag_ram[ctrl.latch_req ? req_idx : idx];
   end

   always_ff @(posedge clock) begin
      if (ctrl.cnt_clear) cnt_ff <= '0;
      else if (ctrl.wb_step || ctrl.fill_step) cnt_ff <= cnt_ff + 1'b1;
   end

   // main memory: reads feed fill, writes take write-back words and sweep
   logic mem_we, cache_we;
   logic [MEMW-1:0] mem_wa;
   logic [31:0] mem_wd;
   logic [OFFW-1:0] cnt_m1;
   assign cnt_m1 = OFFW'(cnt_ff - 1'b1);

   always_comb begin
      mem_we = 1'b0;
      mem_wa = {oldblk, cnt_m1};
      mem_wd = crd_ff;
      if (ctrl.sweep_step) begin
         mem_we = 1'b1;
         mem_wa = sw_ff[MEMW-1:0];
         mem_wd = '0;
      end else if (ctrl.wb_step && (cnt_ff >= (OFFW+1)'(1))) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem_ram[mem_wa] <= mem_wd;
      mrd_ff <= mem_ram[{wa_ff[MEMW-1:OFFW], cnt}];
   end

   logic [CWW-1:0] cache_wa, cache_ra;
   logic [31:0] cache_wd;
   always_comb begin
      cache_we = 1'b0;
      cache_wa = {idx, cnt_m1};
      cache_wd = mrd_ff;
      cache_ra = {idx, cnt};
      if (ctrl.sweep_step) begin
         cache_we = (sw_ff < (SWW+1)'(LINES*WPL));
         cache_wa = sw_ff[CWW-1:0];
         cache_wd = '0;
      end else if (ctrl.fill_step && (cnt_ff >= (OFFW+1)'(1))) begin
         cache_we = 1'b1;
      end else if (ctrl.access) begin
         cache_we = (op_ff == dmwbc_pkg::OP_WRITE);
         cache_wa = {idx, woff};
         cache_wd = wd_ff;
      end
      if (!ctrl.wb_step) cache_ra = {idx, woff};
   end

   always_ff @(posedge clock) begin
      if (cache_we) cache_ram[cache_wa] <= cache_wd;
      crd_ff <= cache_ram[cache_ra];
   end

   always_ff @(posedge clock) begin
      if (ctrl.sweep_step && (sw_ff < (SWW+1)'(LINES))) tag_ram[sw_ff[IDXW-1:0]] <= '0;
      else if (ctrl.fill_done) tag_ram[idx] <= tag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
      end else if (ctrl.fill_done) begin
         valid_ff[idx] <= 1'b1;
         dirty_ff[idx] <= 1'b0;
      end else if (ctrl.access && (op_ff == dmwbc_pkg::OP_WRITE)) begin
         dirty_ff[idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
      end else if (ctrl.respond && (op_ff == dmwbc_pkg::OP_CLEAR)) begin
         time_ff <= '0;
      end else if (ctrl.add_mem_read) begin
         time_ff <= time_ff + {16'd0, mrc_ff};
      end else if (ctrl.add_mem_write) begin
         time_ff <= time_ff + {16'd0, mwc_ff};
      end else if (ctrl.add_cache) begin
         time_ff <= time_ff + {16'd0, (op_ff == dmwbc_pkg::OP_WRITE) ? cwc_ff : crc_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.latch_req) begin
         hit_ff <= 1'b0;
         wb_ff  <= 1'b0;
      end else begin
         if (ctrl.set_hit) hit_ff <= 1'b1;
         if (ctrl.set_wb) wb_ff <= 1'b1;
      end
   end

   // read data settles in the cycle after the access state
   assign rd_word = (op_ff == dmwbc_pkg::OP_READ) ? crd_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= ctrl.respond;
      if (ctrl.respond) begin
         rsp_read_data  <= rd_word;
         rsp_hit        <= hit_ff;
         rsp_wrote_back <= wb_ff;
         rsp_time_now   <= (op_ff == dmwbc_pkg::OP_CLEAR) ? 32'd0 : time_ff;
      end
   end

endmodule

>>> hw/rtl/direct_mapped_writeback_cache_core.sv
// a miss on a dirty line writes the old line back to memory, then fills the new line
//   from memory: one word a cycle each way, behind a registered read of the source
// throughput: one request at a time; busy stays high until the response strobe
// reset: synchronous; after reset a clearing pass zeroes memory, cache and tags while
//   busy is high; csr writes are taken at all times outside reset
module direct_mapped_writeback_cache_core #(
   parameter int LINES        = 256,
   parameter int LINE_BYTES   = 64,
   parameter int MEMORY_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_address,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   output logic [31:0] rsp_read_data,
   output logic        rsp_hit,
   output logic        rsp_wrote_back,
   output logic [31:0] rsp_time_now,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   dmwbc_pkg::ctrl_type   ctrl;
   dmwbc_pkg::status_type status;

   assign csr_ready = 1'b1;

   dmwbc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .ctrl   (ctrl)
   );

   dmwbc_datapath #(
      .LINES        (LINES),
      .LINE_BYTES   (LINE_BYTES),
      .MEMORY_BYTES (MEMORY_BYTES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .status         (status),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_operation  (req_operation),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_read_data  (rsp_read_data),
      .rsp_hit        (rsp_hit),
      .rsp_wrote_back (rsp_wrote_back),
      .rsp_time_now   (rsp_time_now)
   );

endmodule

>>> bench/direct_mapped_writeback_cache_core_test.sv
module direct_mapped_writeback_cache_core_test;

   localparam int LINES = 256;
   localparam int WORDS_PER_LINE = 16;
   localparam int MEM_WORDS = 16384;
   localparam int WATCHDOG_LIMIT = 100000;

   typedef struct {
      logic [31:0] read_data;
      logic        hit;
      logic        wrote_back;
      logic [31:0] time_now;
   } cache_result_type;

   class cache_scoreboard;
      logic [15:0] cost_mem_read, cost_mem_write, cost_cache_read, cost_cache_write;
      bit          valid_mark [LINES];
      bit          dirty_mark [LINES];
      logic [1:0]  tag_mark [LINES];
      logic [31:0] cached_word [LINES*WORDS_PER_LINE];
      logic [31:0] memory_word [MEM_WORDS];
      logic [31:0] clock_count;
      cache_result_type pending_results[$];
      int errors;
      int reads, writes, clears, hits, writebacks, checked;

      function new();
         cost_mem_read = 16'd100;
         cost_mem_write = 16'd50;
         cost_cache_read = 16'd1;
         cost_cache_write = 16'd1;
         foreach (valid_mark[i]) begin
            valid_mark[i] = 0;
            dirty_mark[i] = 0;
            tag_mark[i] = '0;
         end
         foreach (cached_word[i]) cached_word[i] = '0;
         foreach (memory_word[i]) memory_word[i] = '0;
         clock_count = '0;
         errors = 0;
      endfunction

      function void set_cost(logic [1:0] idx, logic [15:0] value);
         case (idx)
            dmwbc_pkg::CSR_MEM_READ_COST: cost_mem_read = value;
            dmwbc_pkg::CSR_MEM_WRITE_COST: cost_mem_write = value;
            dmwbc_pkg::CSR_CACHE_READ_COST: cost_cache_read = value;
            default: cost_cache_write = value;
         endcase
      endfunction

      function void note_request(logic [1:0] op, logic [15:0] addr, logic [31:0] wdata);
         cache_result_type r;
         int blk, line, tag, woff, base, newbase, oldbase;
         r = '{default: '0};
         if (op == dmwbc_pkg::OP_CLEAR) begin
            clock_count = '0;
            clears++;
         end else if (op == dmwbc_pkg::OP_READ || op == dmwbc_pkg::OP_WRITE) begin
            blk = addr / 64;
            line = blk % LINES;
            tag = blk / LINES;
            woff = (addr % 64) / 4;
            base = line * WORDS_PER_LINE;
            if (valid_mark[line] && tag_mark[line] == tag) begin
               r.hit = 1'b1;
               hits++;
            end else begin
               newbase = blk * WORDS_PER_LINE;
               clock_count += cost_mem_read;
               if (valid_mark[line] && dirty_mark[line]) begin
                  oldbase = (tag_mark[line] * LINES + line) * WORDS_PER_LINE;
                  for (int k = 0; k < WORDS_PER_LINE; k++)
                     memory_word[oldbase + k] = cached_word[base + k];
                  clock_count += cost_mem_write;
                  r.wrote_back = 1'b1;
                  writebacks++;
               end
               for (int k = 0; k < WORDS_PER_LINE; k++)
                  cached_word[base + k] = memory_word[newbase + k];
               valid_mark[line] = 1;
               tag_mark[line] = 2'(tag);
               dirty_mark[line] = 0;
            end
            if (op == dmwbc_pkg::OP_READ) begin
               r.read_data = cached_word[base + woff];
               clock_count += cost_cache_read;
               reads++;
            end else begin
               cached_word[base + woff] = wdata;
               clock_count += cost_cache_write;
               dirty_mark[line] = 1;
               writes++;
            end
         end
         r.time_now = clock_count;
         pending_results.push_back(r);
      endfunction

      function void check_result(cache_result_type got);
         cache_result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response read_data %h", $time, got.read_data);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (got.read_data !== want.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                     got.read_data);
            errors++;
         end
         if (got.hit !== want.hit) begin
            $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
            errors++;
         end
         if (got.wrote_back !== want.wrote_back) begin
            $display("%0t: wrote_back expected %b actual %b", $time, want.wrote_back,
                     got.wrote_back);
            errors++;
         end
         if (got.time_now !== want.time_now) begin
            $display("%0t: time_now expected %h actual %h", $time, want.time_now,
                     got.time_now);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_operation = dmwbc_pkg::OP_READ;
   logic [15:0] req_address = '0;
   logic [31:0] req_write_data = '0;
   logic        rsp_valid;
   logic [31:0] rsp_read_data;
   logic        rsp_hit;
   logic        rsp_wrote_back;
   logic [31:0] rsp_time_now;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = dmwbc_pkg::CSR_MEM_READ_COST;
   logic [15:0] csr_data = '0;

   cache_scoreboard board = new();
   int idle_cycles = 0;
   bit no_gaps = 0;

   direct_mapped_writeback_cache_core DUT (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_result('{rsp_read_data, rsp_hit, rsp_wrote_back, rsp_time_now});
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic issue(logic [1:0] op, logic [15:0] addr, logic [31:0] wdata);
      int gap;
      if (!no_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_operation <= op;
      req_address <= addr;
      req_write_data <= wdata;
      do @(posedge clock); while (busy);
      board.note_request(op, addr, wdata);
   endtask

   task automatic drain();
      start <= 0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_cost(logic [1:0] idx, logic [15:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_cost(idx, value);
   endtask

   task automatic set_all_costs(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                logic [15:0] d);
      write_cost(dmwbc_pkg::CSR_MEM_READ_COST, a);
      write_cost(dmwbc_pkg::CSR_MEM_WRITE_COST, b);
      write_cost(dmwbc_pkg::CSR_CACHE_READ_COST, c);
      write_cost(dmwbc_pkg::CSR_CACHE_WRITE_COST, d);
      csr_valid <= 0;
   endtask

   function automatic logic [15:0] pick_address();
      // mostly two hot lines so tags conflict
      logic [15:0] a;
      a = 16'($urandom);
      if ($urandom_range(0, 3) != 0)
         a = {a[15:14], 4'b0000, a[9:8] & 2'b01, 2'b00, a[5:0]};
      return a;
   endfunction

   task automatic random_phase(int count);
      int r;
      logic [1:0] op;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         op = (r < 45) ? dmwbc_pkg::OP_READ : (r < 92) ? dmwbc_pkg::OP_WRITE :
              (r < 97) ? dmwbc_pkg::OP_CLEAR : dmwbc_pkg::OP_NOP;
         issue(op, pick_address(), $urandom);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, tag conflicts, write-back, clear, unused op
      issue(dmwbc_pkg::OP_READ, 16'h0000, 32'h0);
      issue(dmwbc_pkg::OP_WRITE, 16'h0003, 32'hFFFF_FFFF);
      issue(dmwbc_pkg::OP_READ, 16'h0001, 32'h0);
      issue(dmwbc_pkg::OP_WRITE, 16'h003E, 32'hA5A5_5A5A);
      issue(dmwbc_pkg::OP_READ, 16'h4000, 32'h0);
      issue(dmwbc_pkg::OP_READ, 16'h0000, 32'h0);
      issue(dmwbc_pkg::OP_READ, 16'h003C, 32'h0);
      issue(dmwbc_pkg::OP_WRITE, 16'hFFFF, 32'h1234_5678);
      issue(dmwbc_pkg::OP_READ, 16'h3FFC, 32'h0);
      issue(dmwbc_pkg::OP_READ, 16'hFFFC, 32'h0);
      issue(dmwbc_pkg::OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
      issue(dmwbc_pkg::OP_NOP, 16'h1234, 32'hDEAD_BEEF);
      issue(dmwbc_pkg::OP_WRITE, 16'h8000, 32'h0000_0001);
      issue(dmwbc_pkg::OP_READ, 16'hC000, 32'h0);
      issue(dmwbc_pkg::OP_READ, 16'h8000, 32'h0);
      drain();

      set_all_costs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_phase(100);
      drain();
      set_all_costs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      random_phase(60);
      drain();
      set_all_costs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      random_phase(120);
      drain();
      set_all_costs(16'd100, 16'd50, 16'd1, 16'd1);
      no_gaps = 1;
      random_phase(120);
      drain();

      $display("covered %0d reads, %0d writes, %0d clears; %0d hits, %0d write-backs",
               board.reads, board.writes, board.clears, board.hits, board.writebacks);
      $display("%0d responses checked under four cost settings", board.checked);
      if (board.errors == 0 && board.pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
